### rtl/core/stli_pkg.sv
// ============================================================================
// stli_pkg
// Shared types and codes of the sorted table interpolator.
// ============================================================================
package stli_pkg;

    localparam logic [2:0] ST_STORED = 3'd0;
    localparam logic [2:0] ST_FULL   = 3'd1;
    localparam logic [2:0] ST_MATCH  = 3'd2;
    localparam logic [2:0] ST_INTERP = 3'd3;
    localparam logic [2:0] ST_RANGE  = 3'd4;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // request from the table sequencer to the divider
    typedef struct packed {
        logic               start;
        logic signed [33:0] num;
        logic signed [16:0] den;
    } stli_div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [33:0] quo;
    } stli_div_rsp_t;

endpackage

### rtl/core/stli_table_mem.sv
// ============================================================================
// stli_table_mem
// Point store: angle and coefficient in one word, one write and one
// registered read per cycle.
// ============================================================================
module stli_table_mem
    import stli_pkg::*;
#(
    parameter int AW = 5
) (
    input  logic                aclk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  logic [31:0]         wdata,
    input  logic [AW-1:0]       raddr,
    output logic [31:0]         rdata
);

    logic [31:0] mem [0:(1<<AW)-1];
    logic [31:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/stli_divider.sv
// ============================================================================
// stli_divider
// Restoring signed divider, one quotient bit per cycle, truncates to zero.
// ============================================================================
module stli_divider
    import stli_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  stli_div_req_t req,
    output stli_div_rsp_t rsp
);

    logic [33:0] rem_q_reg, rem_q_next;   // dividend shifted into quotient
    logic [16:0] rem_reg, rem_next;
    logic [16:0] dv_reg;
    logic        neg_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [17:0] trial;
    logic [33:0] abs_num;
    logic [16:0] abs_den;

    assign abs_num = req.num[33] ? 34'(-req.num) : req.num;
    assign abs_den = req.den[16] ? 17'(-req.den) : req.den;
    assign trial   = {rem_reg, rem_q_reg[33]} - {1'b0, dv_reg};

    always_comb begin
        rem_q_next = rem_q_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (busy_reg) begin
            if (!trial[17]) begin
                rem_next   = trial[16:0];
                rem_q_next = {rem_q_reg[32:0], 1'b1};
            end else begin
                rem_next   = {rem_reg[15:0], rem_q_reg[33]};
                rem_q_next = {rem_q_reg[32:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (req.start) begin
            rem_q_next = abs_num;
            rem_next   = '0;
            cnt_next   = 6'd34;
            busy_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_q_reg <= rem_q_next;
        rem_reg   <= rem_next;
        if (!busy_reg && req.start) begin
            dv_reg  <= abs_den;
            neg_reg <= req.num[33] ^ req.den[16];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = neg_reg ? 34'(-rem_q_reg) : rem_q_reg;

endmodule

### rtl/core/sorted_table_linear_interpolator_core.sv
// ============================================================================
// sorted_table_linear_interpolator_core
// Sorted (angle, coefficient) table with exact match and linear interpolation.
// ============================================================================
// One item at a time. A load scans down from the top entry, shifting larger
// points up one slot, each shift a read state and a compare state. A query
// scans upward through the table memory, one entry a cycle, to the end of the
// table, then an interpolation runs the serial divider. The result waits in
// an output register.
module sorted_table_linear_interpolator_core
    import stli_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  logic signed [15:0] s_angle,
    input  logic signed [15:0] s_coeff,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_value,
    output logic [2:0]         m_status,
    output logic [5:0]         m_entries
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LRD  = 3'd1;   // load: read entry below slot
    localparam logic [2:0] S_LCHK = 3'd2;   // load: compare, shift or place
    localparam logic [2:0] S_QRD  = 3'd3;   // query scan
    localparam logic [2:0] S_QEND = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] pos_reg, pos_next;     // load slot or query read index
    logic signed [15:0] a_reg, c_reg;
    logic        mv_reg, mv_next;
    logic signed [15:0] mval_reg, mval_next;
    logic [2:0]  mst_reg, mst_next;

    // query scan state
    logic        rd_pend_reg, rd_pend_next;
    logic        found_reg, found_next;
    logic        have_lo_reg, have_lo_next;
    logic        have_hi_reg, have_hi_next;
    logic signed [15:0] lo_a_reg, lo_a_next, lo_c_reg, lo_c_next;
    logic signed [15:0] hi_a_reg, hi_a_next, hi_c_reg, hi_c_next;
    logic signed [15:0] mc_reg, mc_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wdata, rdata;
    logic signed [15:0] r_a, r_c;
    stli_div_req_t dreq;
    stli_div_rsp_t drsp;
    logic signed [34:0] sum;
    logic signed [16:0] dc, da;
    logic signed [33:0] prod;

    assign r_a = rdata[31:16];
    assign r_c = rdata[15:0];

    stli_table_mem #(.AW(AW)) u_mem (
        .aclk (aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    stli_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    assign s_ready = (state_reg == S_IDLE) && !mv_reg;
    assign sum = 35'(lo_c_reg) + 35'(drsp.quo);

    // differences at 17 bits so neither can wrap
    assign dc   = 17'(hi_c_reg) - 17'(lo_c_reg);
    assign da   = 17'(a_reg) - 17'(lo_a_reg);
    assign prod = dc * da;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        mv_next      = mv_reg;
        mval_next    = mval_reg;
        mst_next     = mst_reg;
        rd_pend_next = 1'b0;
        found_next   = found_reg;
        have_lo_next = have_lo_reg;
        have_hi_next = have_hi_reg;
        lo_a_next    = lo_a_reg;
        lo_c_next    = lo_c_reg;
        hi_a_next    = hi_a_reg;
        hi_c_next    = hi_c_reg;
        mc_next      = mc_reg;
        we           = 1'b0;
        waddr        = pos_reg[AW-1:0];
        wdata        = {a_reg, c_reg};
        raddr        = pos_reg[AW-1:0];
        dreq.start   = 1'b0;
        dreq.num     = prod;
        dreq.den     = 17'(hi_a_reg) - 17'(lo_a_reg);
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    if (s_func == FUNC_LOAD) begin
                        if (count_reg >= CW'(TABLE_DEPTH)) begin
                            mval_next  = '0;
                            mst_next   = ST_FULL;
                            state_next = S_OUT;
                        end else begin
                            pos_next   = count_reg;
                            state_next = S_LRD;
                        end
                    end else begin
                        pos_next     = '0;
                        found_next   = 1'b0;
                        have_lo_next = 1'b0;
                        have_hi_next = 1'b0;
                        state_next   = (count_reg == '0) ? S_QEND : S_QRD;
                    end
                end
            end
            S_LRD: begin
                if (pos_reg == '0) begin
                    we         = 1'b1;
                    count_next = count_reg + 1'b1;
                    mval_next  = '0;
                    mst_next   = ST_STORED;
                    state_next = S_OUT;
                end else begin
                    raddr      = AW'(pos_reg - 1'b1);
                    state_next = S_LCHK;
                end
            end
            S_LCHK: begin
                if (r_a > a_reg) begin
                    // move the larger point up one slot
                    we         = 1'b1;
                    wdata      = rdata;
                    pos_next   = pos_reg - 1'b1;
                    state_next = S_LRD;
                end else begin
                    we         = 1'b1;
                    count_next = count_reg + 1'b1;
                    mval_next  = '0;
                    mst_next   = ST_STORED;
                    state_next = S_OUT;
                end
            end
            S_QRD: begin
                if (rd_pend_reg) begin
                    if (r_a == a_reg && !found_reg) begin
                        found_next = 1'b1;
                        mc_next    = r_c;
                    end
                    if (r_a < a_reg) begin
                        have_lo_next = 1'b1;
                        lo_a_next    = r_a;
                        lo_c_next    = r_c;
                    end
                    if (r_a > a_reg && !have_hi_reg) begin
                        have_hi_next = 1'b1;
                        hi_a_next    = r_a;
                        hi_c_next    = r_c;
                    end
                end
                if (pos_reg < count_reg) begin
                    raddr        = pos_reg[AW-1:0];
                    pos_next     = pos_reg + 1'b1;
                    rd_pend_next = 1'b1;
                end else if (!rd_pend_reg) begin
                    state_next = S_QEND;
                end
            end
            S_QEND: begin
                if (found_reg) begin
                    mval_next  = mc_reg;
                    mst_next   = ST_MATCH;
                    state_next = S_OUT;
                end else if (!have_lo_reg || !have_hi_reg) begin
                    mval_next  = '0;
                    mst_next   = ST_RANGE;
                    state_next = S_OUT;
                end else begin
                    dreq.start = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (drsp.done) begin
                    if (sum > 35'sd32767) begin
                        mval_next = 16'sh7fff;
                    end else if (sum < -35'sd32768) begin
                        mval_next = 16'sh8000;
                    end else begin
                        mval_next = sum[15:0];
                    end
                    mst_next   = ST_INTERP;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                mv_next    = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            mv_reg      <= 1'b0;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            mv_reg      <= mv_next;
            rd_pend_reg <= rd_pend_next;
        end
        pos_reg     <= pos_next;
        mval_reg    <= mval_next;
        mst_reg     <= mst_next;
        found_reg   <= found_next;
        have_lo_reg <= have_lo_next;
        have_hi_reg <= have_hi_next;
        lo_a_reg    <= lo_a_next;
        lo_c_reg    <= lo_c_next;
        hi_a_reg    <= hi_a_next;
        hi_c_reg    <= hi_c_next;
        mc_reg      <= mc_next;
        if (s_valid && s_ready) begin
            a_reg  <= s_angle;
            c_reg  <= s_coeff;
        end
    end

    assign m_valid   = mv_reg;
    assign m_value   = mval_reg;
    assign m_status  = mst_reg;
    assign m_entries = 6'(count_reg);

endmodule

### rtl/core/stli_checker.sv
// ============================================================================
// stli_checker
// Port-level checks of the sorted table interpolator.
// ============================================================================
module stli_checker
    import stli_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_value,
    input logic [2:0]         m_status,
    input logic [5:0]         m_entries
);

    // result beat holds until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value) && $stable(m_status))
        else $error("result beat changed while stalled");

    // input beat holds until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("input beat dropped before accept");

    // one item in flight: no input while a result waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input accepted with result pending");

    // loads and range misses carry zero value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_STORED || m_status == ST_FULL
                    || m_status == ST_RANGE) |-> m_value == 16'sd0)
        else $error("nonzero value on non-lookup result");

    // a stored point leaves the table non-empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) && m_status == ST_STORED |-> m_entries != 6'd0)
        else $error("stored point but table empty");

endmodule

bind sorted_table_linear_interpolator_core stli_checker u_stli_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_value(m_value),
    .m_status(m_status), .m_entries(m_entries)
);
